### rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants of the K-weighted short-term meter: field widths, register
// indexes, register reset values and default window lengths.
// ----------------------------------------------------------------------------
package kwm_pkg;

	// field and datapath widths
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 32;
	localparam int HOP_W    = 16;
	localparam int SIG_W    = 40;
	localparam int OUT_W    = 42;
	localparam int SUM_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_CH   = 2;

	// default window lengths in hops and channel count
	localparam int DEF_BLOCK_HOPS      = 4;
	localparam int DEF_SHORT_TERM_HOPS = 30;
	localparam int DEF_CHANNELS        = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHELF_B0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHELF_B1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHELF_B2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHELF_A1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHELF_A2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_A1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_A2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_SAMPLES = 3'd7;

	// register reset values
	localparam logic signed [COEF_W-1:0] RST_SHELF_B0    = 32'sd411043185;
	localparam logic signed [COEF_W-1:0] RST_SHELF_B1    = -32'sd723058035;
	localparam logic signed [COEF_W-1:0] RST_SHELF_B2    = 32'sd319171050;
	localparam logic signed [COEF_W-1:0] RST_SHELF_A1    = -32'sd453857064;
	localparam logic signed [COEF_W-1:0] RST_SHELF_A2    = 32'sd191113264;
	localparam logic signed [COEF_W-1:0] RST_HIGHPASS_A1 = -32'sd536080637;
	localparam logic signed [COEF_W-1:0] RST_HIGHPASS_A2 = 32'sd267356106;
	localparam logic [HOP_W-1:0]         RST_HOP_SAMPLES = 16'd4800;

	// saturated output value
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

endpackage

### rtl/core/k_weighted_short_term_meter.sv
// ----------------------------------------------------------------------------
// k_weighted_short_term_meter
// K-weighting (shelf and high-pass biquads) per channel, hop sums of squares,
// 400 ms and 3 s mean squares and the running short-term maximum.
// ----------------------------------------------------------------------------
// One stereo frame is accepted per item and the block is busy until it is
// processed. All filter and square products go through one shared 33x25
// multiplier: each biquad term is split into two partial products, so a
// biquad forms ten products, then drains the multiplier and rounds, and a
// channel then forms its square. A frame that does not end a hop returns to
// idle after the hop check. Once enough hops are stored, at the last frame
// of a hop the window sums are formed one ring entry per cycle and each mean
// goes through a one-bit-per-cycle 64-bit divider, and the result then waits
// until the output register is free. A finished result is held in an output
// register while the next frame is taken in.
module k_weighted_short_term_meter import kwm_pkg::*; #(
	parameter int BLOCK_HOPS      = DEF_BLOCK_HOPS,
	parameter int SHORT_TERM_HOPS = DEF_SHORT_TERM_HOPS,
	parameter int CHANNELS        = DEF_CHANNELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [COEF_W-1:0]           cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_left,
	input  logic signed [SAMPLE_W-1:0]  sample_right,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [OUT_W-1:0]            block_mean_square,
	output logic                        block_ready,
	output logic [OUT_W-1:0]            short_term_mean_square,
	output logic                        short_term_ready,
	output logic [OUT_W-1:0]            short_term_max
);

	localparam int RING_DEPTH = (BLOCK_HOPS > SHORT_TERM_HOPS) ? BLOCK_HOPS : SHORT_TERM_HOPS;
	localparam int HOPS_W     = $clog2(RING_DEPTH + 1);
	localparam int RING_W     = $clog2(RING_DEPTH);
	localparam int DVS_W      = HOP_W + HOPS_W;
	localparam int ACC_W      = 76;
	localparam int MA_W       = 33;
	localparam int MB_W       = 25;
	localparam int PROD_W     = MA_W + MB_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MAC   = 4'd1;
	localparam logic [3:0] ST_DRAIN = 4'd2;
	localparam logic [3:0] ST_ROUND = 4'd3;
	localparam logic [3:0] ST_SQ    = 4'd4;
	localparam logic [3:0] ST_SQACC = 4'd5;
	localparam logic [3:0] ST_HOP   = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_DIVGO = 4'd8;
	localparam logic [3:0] ST_DIVW  = 4'd9;
	localparam logic [3:0] ST_EMIT  = 4'd10;

	// configuration registers
	logic signed [COEF_W-1:0] shelf_b0_q, shelf_b1_q, shelf_b2_q, shelf_a1_q, shelf_a2_q;
	logic signed [COEF_W-1:0] hp_a1_q, hp_a2_q;
	logic [HOP_W-1:0]         hop_samples_q;

	// sequencer and datapath state
	logic [3:0]               state_q;
	logic                     ch_q;
	logic                     filt_q;
	logic [3:0]               step_q;
	logic signed [SIG_W-1:0]  cur_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic signed [SIG_W-1:0]  hist_q [2][MAX_CH][4];
	logic signed [PROD_W-1:0] prod_q;
	logic                     sh_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SIG_W-1:0]  y_q;
	logic                     sat_q;
	logic [HOP_W-1:0]         pos_q;
	logic [SUM_W-1:0]         hop_acc_q;
	logic [SUM_W-1:0]         ring_q [RING_DEPTH];
	logic [HOPS_W-1:0]        hops_q;
	logic                     blk_ok_q, st_ok_q;
	logic                     win_q;
	logic [HOPS_W-1:0]        win_n_q;
	logic [RING_W-1:0]        idx_q;
	logic [SUM_W-1:0]         sum_q;
	logic [OUT_W-1:0]         blk_q, st_q, max_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         o_blk_q, o_st_q, o_max_q;
	logic                     o_blk_ok_q, o_st_ok_q;

	// combinational signals
	logic [2:0]               term;
	logic signed [SIG_W-1:0]  opnd;
	logic signed [MA_W-1:0]   coef;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_add;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-29:0] y_full;
	logic signed [SIG_W-1:0]  y_sat;
	logic [SIG_W-1:0]         y_mag;
	logic [HOP_W-1:0]         hop_len;
	logic [HOPS_W-1:0]        hops_next;
	logic [SUM_W:0]           sum_add;
	logic [SUM_W-1:0]         sum_sat;
	logic [DVS_W-1:0]         divisor;
	logic                     div_start, div_done;
	logic [SUM_W-1:0]         div_quo;
	logic [OUT_W-1:0]         mean_sat;
	logic [SIG_W-1:0]         y_neg;
	logic                     emit_go;

	// coefficient and operand selection for the current term
	assign term = step_q[3:1];

	always_comb begin
		coef = '0;
		case ({filt_q, term})
			4'b0_000: coef = MA_W'(shelf_b0_q);
			4'b0_001: coef = MA_W'(shelf_b1_q);
			4'b0_010: coef = MA_W'(shelf_b2_q);
			4'b0_011: coef = -MA_W'(shelf_a1_q);
			4'b0_100: coef = -MA_W'(shelf_a2_q);
			4'b1_000: coef = MA_W'(34'sd1 <<< 28);
			4'b1_001: coef = -MA_W'(34'sd1 <<< 29);
			4'b1_010: coef = MA_W'(34'sd1 <<< 28);
			4'b1_011: coef = -MA_W'(hp_a1_q);
			4'b1_100: coef = -MA_W'(hp_a2_q);
			default:  coef = '0;
		endcase
	end

	always_comb begin
		opnd = cur_q;
		if (term != 3'd0) begin
			opnd = hist_q[filt_q][ch_q][2'(term - 3'd1)];
		end
	end

	// magnitude for the square
	assign y_neg = -y_q;
	assign y_mag = y_q[SIG_W-1] ? y_neg : y_q;

	// shared multiplier operands
	always_comb begin
		if (state_q == ST_SQ) begin
			mul_a = MA_W'({1'b0, y_mag[23:0]});
			mul_b = MB_W'({1'b0, y_mag[23:0]});
		end else begin
			mul_a = coef;
			mul_b = step_q[0] ? MB_W'(signed'(opnd[SIG_W-1:20])) : MB_W'({1'b0, opnd[19:0]});
		end
	end

	// accumulate path
	assign prod_ext = ACC_W'(prod_q);
	assign acc_add  = acc_q + (sh_q ? (prod_ext <<< 20) : prod_ext);

	// round half up, shift by 28, saturate to 40 bits
	assign rnd    = acc_q + (ACC_W'(1) <<< 27);
	assign y_full = rnd[ACC_W-1:28];
	always_comb begin
		if (y_full[ACC_W-29:SIG_W-1] == '0 || y_full[ACC_W-29:SIG_W-1] == '1) begin
			y_sat = y_full[SIG_W-1:0];
		end else if (y_full[ACC_W-29]) begin
			y_sat = {1'b1, {(SIG_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SIG_W-1){1'b1}}};
		end
	end

	// hop bookkeeping
	assign hop_len   = (hop_samples_q == '0) ? HOP_W'(1) : hop_samples_q;
	assign hops_next = (hops_q < HOPS_W'(RING_DEPTH)) ? hops_q + 1'b1 : hops_q;

	// saturating window sum
	assign sum_add = {1'b0, sum_q} + {1'b0, ring_q[idx_q]};
	assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

	// window length in frames and saturated quotient
	assign divisor  = DVS_W'(hop_len) * DVS_W'(win_n_q);
	assign mean_sat = (div_quo[SUM_W-1:OUT_W] != '0) ? OUT_MAX : div_quo[OUT_W-1:0];
	assign div_start = (state_q == ST_DIVGO);

	// result moves into the output register
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	kwm_divider #(
		.DVD_W (SUM_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shelf_b0_q    <= RST_SHELF_B0;
			shelf_b1_q    <= RST_SHELF_B1;
			shelf_b2_q    <= RST_SHELF_B2;
			shelf_a1_q    <= RST_SHELF_A1;
			shelf_a2_q    <= RST_SHELF_A2;
			hp_a1_q       <= RST_HIGHPASS_A1;
			hp_a2_q       <= RST_HIGHPASS_A2;
			hop_samples_q <= RST_HOP_SAMPLES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHELF_B0:    shelf_b0_q    <= cfg_data;
				REG_SHELF_B1:    shelf_b1_q    <= cfg_data;
				REG_SHELF_B2:    shelf_b2_q    <= cfg_data;
				REG_SHELF_A1:    shelf_a1_q    <= cfg_data;
				REG_SHELF_A2:    shelf_a2_q    <= cfg_data;
				REG_HIGHPASS_A1: hp_a1_q       <= cfg_data;
				REG_HIGHPASS_A2: hp_a2_q       <= cfg_data;
				REG_HOP_SAMPLES: hop_samples_q <= cfg_data[HOP_W-1:0];
				default: ;
			endcase
		end
	end

	// multiplier output register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		sh_q   <= step_q[0];
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			filt_q      <= 1'b0;
			step_q      <= '0;
			hist_q      <= '{default: '0};
			pos_q       <= '0;
			hop_acc_q   <= '0;
			ring_q      <= '{default: '0};
			hops_q      <= '0;
			max_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cur_q   <= SIG_W'(sample_left);
						right_q <= sample_right;
						ch_q    <= 1'b0;
						filt_q  <= 1'b0;
						step_q  <= '0;
						acc_q   <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (step_q != '0) begin
						acc_q <= acc_add;
					end
					step_q <= step_q + 1'b1;
					if (step_q == 4'd9) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					acc_q   <= acc_add;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					hist_q[filt_q][ch_q][1] <= hist_q[filt_q][ch_q][0];
					hist_q[filt_q][ch_q][0] <= cur_q;
					hist_q[filt_q][ch_q][3] <= hist_q[filt_q][ch_q][2];
					hist_q[filt_q][ch_q][2] <= y_sat;
					step_q <= '0;
					acc_q  <= '0;
					if (!filt_q) begin
						cur_q   <= y_sat;
						filt_q  <= 1'b1;
						state_q <= ST_MAC;
					end else begin
						y_q     <= y_sat;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					sat_q   <= (y_mag[SIG_W-1:24] != '0);
					state_q <= ST_SQACC;
				end
				ST_SQACC: begin
					hop_acc_q <= hop_acc_q + SUM_W'(sat_q ? OUT_MAX : prod_q[47:6]);
					if (32'(ch_q) < CHANNELS - 1) begin
						ch_q    <= 1'b1;
						filt_q  <= 1'b0;
						step_q  <= '0;
						acc_q   <= '0;
						cur_q   <= SIG_W'(right_q);
						state_q <= ST_MAC;
					end else begin
						state_q <= ST_HOP;
					end
				end
				ST_HOP: begin
					if ({1'b0, pos_q} + 1'b1 < {1'b0, hop_len}) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ring_q[0] <= hop_acc_q;
						for (int i = 1; i < RING_DEPTH; i++) begin
							ring_q[i] <= ring_q[i-1];
						end
						hop_acc_q <= '0;
						pos_q     <= '0;
						hops_q    <= hops_next;
						blk_ok_q  <= (hops_next >= HOPS_W'(BLOCK_HOPS));
						st_ok_q   <= (hops_next >= HOPS_W'(SHORT_TERM_HOPS));
						blk_q     <= '0;
						st_q      <= '0;
						idx_q     <= '0;
						sum_q     <= '0;
						if (hops_next >= HOPS_W'(BLOCK_HOPS)) begin
							win_q   <= 1'b0;
							win_n_q <= HOPS_W'(BLOCK_HOPS);
							state_q <= ST_SUM;
						end else if (hops_next >= HOPS_W'(SHORT_TERM_HOPS)) begin
							win_q   <= 1'b1;
							win_n_q <= HOPS_W'(SHORT_TERM_HOPS);
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SUM: begin
					sum_q <= sum_sat;
					idx_q <= idx_q + 1'b1;
					if (HOPS_W'(idx_q) == win_n_q - 1'b1) begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						if (!win_q) begin
							blk_q <= mean_sat;
							if (st_ok_q) begin
								win_q   <= 1'b1;
								win_n_q <= HOPS_W'(SHORT_TERM_HOPS);
								idx_q   <= '0;
								sum_q   <= '0;
								state_q <= ST_SUM;
							end else begin
								state_q <= ST_EMIT;
							end
						end else begin
							st_q <= mean_sat;
							if (mean_sat > max_q) begin
								max_q <= mean_sat;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						o_blk_q     <= blk_q;
						o_blk_ok_q  <= blk_ok_q;
						o_st_q      <= st_q;
						o_st_ok_q   <= st_ok_q;
						o_max_q     <= max_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready               = (state_q == ST_IDLE);
	assign out_valid              = out_valid_q;
	assign block_mean_square      = o_blk_q;
	assign block_ready            = o_blk_ok_q;
	assign short_term_mean_square = o_st_q;
	assign short_term_ready       = o_st_ok_q;
	assign short_term_max         = o_max_q;

endmodule

### rtl/core/kwm_divider.sv
// ----------------------------------------------------------------------------
// kwm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kwm_divider import kwm_pkg::*; #(
	parameter int DVD_W = SUM_W,
	parameter int DVS_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             fits;

	// trial subtraction
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign fits   = (rem_sh >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
